[hdl/bsdl_pkg.sv]
// ----------------------------------------------------------------------------
// bsdl_pkg
// Shared types and constants for the bounded sorted distance list.
// ----------------------------------------------------------------------------
package bsdl_pkg;

   localparam int LIST_DEPTH_DEFAULT = 32;
   localparam int TAG_W              = 16;
   localparam int KEY_W              = 20;
   localparam int INDEX_W            = 5;
   localparam int POS_W              = 6;
   localparam int COUNT_W            = 6;
   localparam int STATUS_W           = 2;

   typedef enum logic [1:0] {
      FUNC_CLEAR  = 2'd0,
      FUNC_INSERT = 2'd1,
      FUNC_REMOVE = 2'd2,
      FUNC_READ   = 2'd3
   } func_type;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_INDEX = 2'd2;

   typedef struct packed {
      func_type           func;
      logic [TAG_W-1:0]   tag;
      logic [KEY_W-1:0]   key;
      logic [INDEX_W-1:0] index;
   } req_word_type;

   typedef struct packed {
      logic [TAG_W-1:0]    entry_tag;
      logic [KEY_W-1:0]    entry_key;
      logic                entry_valid;
      logic [POS_W-1:0]    position;
      logic [COUNT_W-1:0]  count;
      logic [STATUS_W-1:0] status;
   } rsp_word_type;

   typedef struct packed {
      logic insert;
      logic remove;
      logic active;
      logic after_index;
   } cell_ctl_type;

endpackage

[hdl/bsdl_cell.sv]
// ----------------------------------------------------------------------------
// bsdl_cell
// One list slot: holds a tag and key, compares against the incoming key and
// shifts to or from its neighbours on insert and remove.
// ----------------------------------------------------------------------------
module bsdl_cell (
   input  logic                     clock,
   input  bsdl_pkg::cell_ctl_type   ctl,
   input  logic [bsdl_pkg::TAG_W-1:0] new_tag,
   input  logic [bsdl_pkg::KEY_W-1:0] new_key,
   input  logic                     left_gt,
   input  logic [bsdl_pkg::TAG_W-1:0] left_tag,
   input  logic [bsdl_pkg::KEY_W-1:0] left_key,
   input  logic [bsdl_pkg::TAG_W-1:0] right_tag,
   input  logic [bsdl_pkg::KEY_W-1:0] right_key,
   output logic                     gt,
   output logic [bsdl_pkg::TAG_W-1:0] tag,
   output logic [bsdl_pkg::KEY_W-1:0] key
);
   import bsdl_pkg::*;

   logic [TAG_W-1:0] tag_ff, tag_in;
   logic [KEY_W-1:0] key_ff, key_in;

   assign gt  = ctl.active && (new_key > key_ff);
   assign tag = tag_ff;
   assign key = key_ff;

   always_comb begin
      tag_in = tag_ff;
      key_in = key_ff;
      priority if (ctl.insert && !gt) begin
         if (left_gt) begin
            tag_in = new_tag;
            key_in = new_key;
         end else begin
            tag_in = left_tag;
            key_in = left_key;
         end
      end else if (ctl.remove && ctl.after_index) begin
         tag_in = right_tag;
         key_in = right_key;
      end else begin
         tag_in = tag_ff;
         key_in = key_ff;
      end
   end

   always_ff @(posedge clock) begin
      tag_ff <= tag_in;
      key_ff <= key_in;
   end

endmodule

[hdl/bounded_sorted_distance_list.sv]
// ----------------------------------------------------------------------------
// bounded_sorted_distance_list
// Keeps up to LIST_DEPTH (tag, key) entries sorted by ascending key.
// ----------------------------------------------------------------------------
// Usage:
//   Request words (req_valid, req_stall, req_word) carry clear, insert,
//   remove at index or read at index. Every request gives exactly one
//   response word on rsp_valid, rsp_stall, rsp_word.
//   The response is registered at the edge that takes the request. One request
//   per cycle is sustained while the receiver does not stall; each cell of the
//   chain compares and shifts in parallel, so every operation ends at that edge.
//   An insert goes in front of the first entry whose key is not smaller; on a
//   full list the last entry drops out and is returned. An insert that would
//   land past the end of a full list is rejected with status full.
//   Remove or read at an index not below the count returns status bad index.
//   Reset empties the list and drops any pending response. While the
//   receiver stalls, the response word holds and req_stall is raised, so no
//   new request is taken until the response is gone.
// ----------------------------------------------------------------------------
module bounded_sorted_distance_list #(
   parameter int LIST_DEPTH = bsdl_pkg::LIST_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  bsdl_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output bsdl_pkg::rsp_word_type rsp_word
);
   import bsdl_pkg::*;

   localparam int CW = $clog2(LIST_DEPTH + 1);
   localparam int XW = (CW > INDEX_W) ? CW : INDEX_W;

   logic                   accept;
   logic [CW-1:0]          count_ff, count_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_word_type           rsp_word_ff, rsp_word_in;

   logic [XW-1:0]          idx_x, count_x;
   logic                   full, reject, idx_ok;
   logic                   do_insert, do_remove;

   logic                   gt      [LIST_DEPTH];
   logic                   left_gt [LIST_DEPTH];
   logic                   sel     [LIST_DEPTH];
   logic [TAG_W-1:0]       c_tag   [LIST_DEPTH];
   logic [KEY_W-1:0]       c_key   [LIST_DEPTH];
   logic [TAG_W-1:0]       l_tag   [LIST_DEPTH];
   logic [KEY_W-1:0]       l_key   [LIST_DEPTH];
   logic [TAG_W-1:0]       r_tag   [LIST_DEPTH];
   logic [KEY_W-1:0]       r_key   [LIST_DEPTH];
   cell_ctl_type           ctl     [LIST_DEPTH];

   logic [CW-1:0]          pos_found;
   logic [TAG_W-1:0]       read_tag;
   logic [KEY_W-1:0]       read_key;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   assign idx_x     = XW'(req_word.index);
   assign count_x   = XW'(count_ff);
   assign full      = (count_ff == CW'(LIST_DEPTH));
   assign reject    = gt[LIST_DEPTH-1];
   assign idx_ok    = (idx_x < count_x);
   assign do_insert = accept && (req_word.func == FUNC_INSERT) && !reject;
   assign do_remove = accept && (req_word.func == FUNC_REMOVE) && idx_ok;

   // neighbour wiring and per-cell control
   always_comb begin
      for (int i = 0; i < LIST_DEPTH; i++) begin
         if (i == 0) begin
            left_gt[i] = 1'b1;
            l_tag[i]   = req_word.tag;
            l_key[i]   = req_word.key;
         end else begin
            left_gt[i] = gt[i-1];
            l_tag[i]   = c_tag[i-1];
            l_key[i]   = c_key[i-1];
         end
         if (i == LIST_DEPTH - 1) begin
            r_tag[i] = c_tag[i];
            r_key[i] = c_key[i];
         end else begin
            r_tag[i] = c_tag[i+1];
            r_key[i] = c_key[i+1];
         end
         sel[i]                = (idx_x == XW'(i));
         ctl[i].insert         = do_insert;
         ctl[i].remove         = do_remove;
         ctl[i].active         = (XW'(i) < count_x);
         ctl[i].after_index    = (idx_x <= XW'(i));
      end
   end

   for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
      bsdl_cell u_cell (
         .clock     (clock),
         .ctl       (ctl[g]),
         .new_tag   (req_word.tag),
         .new_key   (req_word.key),
         .left_gt   (left_gt[g]),
         .left_tag  (l_tag[g]),
         .left_key  (l_key[g]),
         .right_tag (r_tag[g]),
         .right_key (r_key[g]),
         .gt        (gt[g]),
         .tag       (c_tag[g]),
         .key       (c_key[g])
      );
   end

   // encode insert point and select read entry
   always_comb begin
      pos_found = reject ? CW'(LIST_DEPTH) : '0;
      read_tag  = '0;
      read_key  = '0;
      for (int i = 0; i < LIST_DEPTH; i++) begin
         if (left_gt[i] && !gt[i]) begin
            pos_found = pos_found | CW'(i);
         end
         if (sel[i]) begin
            read_tag = read_tag | c_tag[i];
            read_key = read_key | c_key[i];
         end
      end
   end

   always_comb begin
      count_in    = count_ff;
      rsp_word_in = rsp_word_ff;
      if (accept) begin
         rsp_word_in             = '0;
         rsp_word_in.status      = STATUS_OK;
         unique case (req_word.func)
            FUNC_CLEAR: begin
               count_in = '0;
            end
            FUNC_INSERT: begin
               if (reject) begin
                  rsp_word_in.position = POS_W'(pos_found);
                  rsp_word_in.status   = STATUS_FULL;
               end else begin
                  rsp_word_in.position = POS_W'(pos_found);
                  if (full) begin
                     rsp_word_in.entry_tag   = c_tag[LIST_DEPTH-1];
                     rsp_word_in.entry_key   = c_key[LIST_DEPTH-1];
                     rsp_word_in.entry_valid = 1'b1;
                  end else begin
                     count_in = count_ff + CW'(1);
                  end
               end
            end
            FUNC_REMOVE, FUNC_READ: begin
               if (idx_ok) begin
                  rsp_word_in.entry_tag   = read_tag;
                  rsp_word_in.entry_key   = read_key;
                  rsp_word_in.entry_valid = 1'b1;
                  if (req_word.func == FUNC_REMOVE) begin
                     count_in = count_ff - CW'(1);
                  end
               end else begin
                  rsp_word_in.status = STATUS_BAD_INDEX;
               end
            end
            default: begin
               count_in = count_ff;
            end
         endcase
         rsp_word_in.count = COUNT_W'(count_in);
      end
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

endmodule

[hdl/bsdl_checker.sv]
// ----------------------------------------------------------------------------
// bsdl_checker
// Port-level checks for the bounded sorted distance list.
// ----------------------------------------------------------------------------
module bsdl_checker #(
   parameter int LIST_DEPTH = bsdl_pkg::LIST_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  bsdl_pkg::rsp_word_type rsp_word
);
   import bsdl_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("stalled response word changed");

   a_req_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("accepted request gave no response");

   a_full_reject: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_word.status == STATUS_FULL) |->
         !rsp_word.entry_valid && (rsp_word.position == POS_W'(LIST_DEPTH)))
      else $error("rejected insert carries an entry or a wrong position");

   a_entry_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.entry_valid |-> rsp_word.status == STATUS_OK)
      else $error("entry returned with an error status");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind bounded_sorted_distance_list bsdl_checker #(.LIST_DEPTH(LIST_DEPTH)) u_bsdl_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_word  (rsp_word)
);

[sim/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bounded sorted distance list. Every accepted
// request word is run through a local copy of the sorted list, and the word
// it must give back is queued. Each response word is compared field by field
// with the oldest queued one. The run covers a directed pass over the edge
// cases, a full list with eviction and rejection, a long receiver hold-off,
// and random sequences with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_top;
   import bsdl_pkg::*;

   localparam int LIST_DEPTH = LIST_DEPTH_DEFAULT;
   localparam int WORD_TARGET = 450;

   logic         clock;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_word = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_word;

   logic [TAG_W-1:0] list_tag [LIST_DEPTH];
   logic [KEY_W-1:0] list_key [LIST_DEPTH];
   int               list_count = 0;

   rsp_word_type replies_due[$];
   int           fault_count = 0;
   int           words_sent = 0;
   bit           tx_idle_on = 1'b0;
   bit           rx_idle_on = 1'b0;
   int           hold_request = 0;
   int           hold_left = 0;
   int           stall_run = 0;

   bounded_sorted_distance_list #(.LIST_DEPTH(LIST_DEPTH)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_word (req_word),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_word (rsp_word)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   function automatic int gap_length();
      if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
      return $urandom_range(0, 3);
   endfunction

   function automatic rsp_word_type apply_list_op(input req_word_type w);
      rsp_word_type r;
      int           slot;
      int           i;
      r = '0;
      case (w.func)
         FUNC_CLEAR: begin
            list_count = 0;
         end
         FUNC_INSERT: begin
            slot = 0;
            while (slot < list_count && w.key > list_key[slot]) slot++;
            r.position = POS_W'(slot);
            if (slot >= LIST_DEPTH) begin
               r.status = STATUS_FULL;
            end else begin
               if (list_count == LIST_DEPTH) begin
                  r.entry_tag   = list_tag[LIST_DEPTH-1];
                  r.entry_key   = list_key[LIST_DEPTH-1];
                  r.entry_valid = 1'b1;
               end else begin
                  list_count++;
               end
               for (i = list_count - 1; i > slot; i--) begin
                  list_tag[i] = list_tag[i-1];
                  list_key[i] = list_key[i-1];
               end
               list_tag[slot] = w.tag;
               list_key[slot] = w.key;
            end
         end
         default: begin
            if (w.index >= list_count) begin
               r.status = STATUS_BAD_INDEX;
            end else begin
               r.entry_tag   = list_tag[w.index];
               r.entry_key   = list_key[w.index];
               r.entry_valid = 1'b1;
               if (w.func == FUNC_REMOVE) begin
                  for (i = w.index; i + 1 < list_count; i++) begin
                     list_tag[i] = list_tag[i+1];
                     list_key[i] = list_key[i+1];
                  end
                  list_count--;
               end
            end
         end
      endcase
      r.count = COUNT_W'(list_count);
      return r;
   endfunction

   function automatic req_word_type pick_list_op(input int insert_pct, input bit tight_keys,
                                                 input bit noisy);
      req_word_type w;
      int           roll;
      w       = '0;
      w.tag   = TAG_W'($urandom);
      w.key   = tight_keys ? KEY_W'($urandom_range(0, 15)) : KEY_W'($urandom);
      w.index = INDEX_W'($urandom);
      roll    = $urandom_range(0, 99);
      if ($urandom_range(0, 19) == 0) w.key = roll[0] ? '1 : '0;
      if (noisy) begin
         w.func = func_type'($urandom_range(0, 3));
      end else begin
         if (roll < 2) w.func = FUNC_CLEAR;
         else if (roll < insert_pct) w.func = FUNC_INSERT;
         else if (roll[0]) w.func = FUNC_READ;
         else w.func = FUNC_REMOVE;
         if (list_count > 0 && $urandom_range(0, 9) != 0)
            w.index = INDEX_W'($urandom_range(0, list_count - 1));
      end
      return w;
   endfunction

   task automatic pause_sender(input int cycles);
      if (cycles > 0) begin
         req_valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   task automatic send_word(input req_word_type w);
      req_word  <= w;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      replies_due.push_back(apply_list_op(w));
      words_sent++;
      if (tx_idle_on) pause_sender(gap_length());
   endtask

   task automatic send_op(input func_type f, input logic [TAG_W-1:0] tag,
                          input logic [KEY_W-1:0] key, input logic [INDEX_W-1:0] index);
      req_word_type w;
      w.func  = f;
      w.tag   = tag;
      w.key   = key;
      w.index = index;
      send_word(w);
   endtask

   task automatic wait_for_replies();
      req_valid <= 1'b0;
      while (replies_due.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // receiver: long hold-off on request, else random stall runs
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (hold_request > 0) begin
         hold_left    = hold_request - 1;
         hold_request = 0;
         rsp_stall <= 1'b1;
      end else if (stall_run > 0) begin
         stall_run--;
      end else begin
         rsp_stall <= rx_idle_on && ($urandom_range(0, 99) < 40);
         stall_run = gap_length();
      end
   end

   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (replies_due.size() == 0) begin
            $error("response word with none due: %h", rsp_word);
            fault_count++;
         end else begin
            want = replies_due.pop_front();
            if (rsp_word.entry_tag !== want.entry_tag) begin
               $error("entry_tag: expected %0h, got %0h", want.entry_tag, rsp_word.entry_tag);
               fault_count++;
            end
            if (rsp_word.entry_key !== want.entry_key) begin
               $error("entry_key: expected %0h, got %0h", want.entry_key, rsp_word.entry_key);
               fault_count++;
            end
            if (rsp_word.entry_valid !== want.entry_valid) begin
               $error("entry_valid: expected %0b, got %0b", want.entry_valid,
                      rsp_word.entry_valid);
               fault_count++;
            end
            if (rsp_word.position !== want.position) begin
               $error("position: expected %0d, got %0d", want.position, rsp_word.position);
               fault_count++;
            end
            if (rsp_word.count !== want.count) begin
               $error("count: expected %0d, got %0d", want.count, rsp_word.count);
               fault_count++;
            end
            if (rsp_word.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_word.status);
               fault_count++;
            end
         end
      end
   end

   task automatic test_directed();
      tx_idle_on = 1'b1;
      rx_idle_on = 1'b1;
      send_op(FUNC_CLEAR, 16'h0, 20'h0, 5'd0);
      send_op(FUNC_REMOVE, 16'h0, 20'h0, 5'd0);
      send_op(FUNC_READ, 16'hFFFF, 20'hFFFFF, 5'd0);
      send_op(FUNC_INSERT, 16'hFFFF, 20'hFFFFF, 5'd31);
      send_op(FUNC_INSERT, 16'h0000, 20'h00000, 5'd0);
      send_op(FUNC_INSERT, 16'h1234, 20'h00000, 5'd0);
      send_op(FUNC_INSERT, 16'hA5A5, 20'h5A5A5, 5'd0);
      send_op(FUNC_READ, 16'h0, 20'h0, 5'd0);
      send_op(FUNC_READ, 16'h0, 20'h0, 5'd3);
      send_op(FUNC_READ, 16'h0, 20'h0, 5'd31);
      send_op(FUNC_READ, 16'h0, 20'h0, 5'd4);
      send_op(FUNC_REMOVE, 16'h0, 20'h0, 5'd1);
      send_op(FUNC_REMOVE, 16'h0, 20'h0, 5'd3);
      send_op(FUNC_REMOVE, 16'h0, 20'h0, 5'd2);
      send_op(FUNC_READ, 16'h0, 20'h0, 5'd1);
      send_op(FUNC_CLEAR, 16'hFFFF, 20'hFFFFF, 5'd31);
      send_op(FUNC_READ, 16'h0, 20'h0, 5'd0);
      wait_for_replies();
   endtask

   task automatic test_full_list();
      tx_idle_on = 1'b1;
      rx_idle_on = 1'b1;
      send_op(FUNC_CLEAR, 16'h0, 20'h0, 5'd0);
      repeat (LIST_DEPTH)
         send_op(FUNC_INSERT, TAG_W'($urandom), KEY_W'($urandom_range(1, 20'hFFFFE)), 5'd0);
      send_op(FUNC_INSERT, 16'hBEEF, 20'hFFFFF, 5'd0);
      send_op(FUNC_INSERT, 16'hFFFF, 20'h00000, 5'd0);
      send_op(FUNC_INSERT, 16'h0F0F, list_key[LIST_DEPTH-1], 5'd0);
      send_op(FUNC_READ, 16'h0, 20'h0, 5'd31);
      send_op(FUNC_REMOVE, 16'h0, 20'h0, 5'd31);
      send_op(FUNC_READ, 16'h0, 20'h0, 5'd31);
      send_op(FUNC_INSERT, 16'hC3C3, 20'hFFFFF, 5'd0);
      send_op(FUNC_REMOVE, 16'h0, 20'h0, 5'd0);
      wait_for_replies();
   endtask

   task automatic test_backpressure();
      tx_idle_on   = 1'b0;
      rx_idle_on   = 1'b0;
      hold_request = 150;
      repeat (24) send_word(pick_list_op(70, 1'b0, 1'b0));
      wait_for_replies();
   endtask

   task automatic test_random();
      int  run_len;
      int  mode;
      int  insert_pct;
      bit  tight_keys;
      bit  noisy;
      while (words_sent < WORD_TARGET) begin
         mode       = $urandom_range(0, 3);
         tx_idle_on = mode[0];
         rx_idle_on = mode[1];
         noisy      = ($urandom_range(0, 99) < 15);
         tight_keys = $urandom_range(0, 2) == 0;
         case ($urandom_range(0, 2))
            0: insert_pct = 80;
            1: insert_pct = 55;
            default: insert_pct = 30;
         endcase
         run_len = $urandom_range(15, 60);
         repeat (run_len) send_word(pick_list_op(insert_pct, tight_keys, noisy));
         if ($urandom_range(0, 3) == 0) wait_for_replies();
      end
      wait_for_replies();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_full_list();
      test_backpressure();
      test_random();
      repeat (4) @(posedge clock);
      if (replies_due.size() != 0) begin
         $error("%0d response words never arrived", replies_due.size());
         fault_count++;
      end
      if (fault_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

[filelist.f]
hdl/bsdl_pkg.sv
hdl/bsdl_cell.sv
hdl/bounded_sorted_distance_list.sv
hdl/bsdl_checker.sv
sim/tb_top.sv
